// ===== rtl/core/tet_pkg.sv =====
// ----------------------------------------------------------------------------
// tet_pkg: shared definitions for the tracked emitter table
// Codes, field widths and reset values used by the table core.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int unsigned TableEntriesDefault = 32;

  localparam logic [31:0] ExpireLimitReset = 32'd300000;
  localparam logic [15:0] SweepPeriodReset = 16'd1000;

  localparam int unsigned IdW    = 160;
  localparam int unsigned AddrW  = 48;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LinkW  = 15;
  localparam int unsigned PosW   = 64;

  localparam int unsigned InDataW  = 352;
  localparam int unsigned OutDataW = 72;

  // input action codes
  localparam logic [1:0] ActDetect = 2'd0;
  localparam logic [1:0] ActTick   = 2'd1;
  localparam logic [1:0] ActClear  = 2'd2;

  // result outcome codes
  localparam logic [2:0] OutIdHit   = 3'd0;
  localparam logic [2:0] OutAddrHit = 3'd1;
  localparam logic [2:0] OutFree    = 3'd2;
  localparam logic [2:0] OutEvict   = 3'd3;
  localparam logic [2:0] OutTick    = 3'd4;
  localparam logic [2:0] OutSweep   = 3'd5;

  // configuration register byte addresses
  localparam logic [2:0] RegExpireLimit = 3'd0;
  localparam logic [2:0] RegSweepPeriod = 3'd4;

endpackage

// ===== rtl/core/tracked_emitter_table_core.sv =====
// ----------------------------------------------------------------------------
// tracked_emitter_table_core: table of tracked radio emitters
// Matches detections by ID then address, allocates or evicts slots, and
// expires stale entries on periodic sweeps driven by millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer: tuser is the action (detection,
//   tick, clear), tdata the detection fields. m_axis returns exactly one
//   result per item: tuser is the outcome, tdata slot, evicted address and counts.
//   The APB port holds the expiry limit (0x0) and the sweep period (0x4);
//   write it only while the block is idle.
// Timing:
//   Items are handled one at a time. A detection scans the table through
//   the entry memory, one read per cycle, then reads and writes back the
//   chosen slot and gives its result. A tick that sweeps runs the same
//   scan and then gives its result; a plain tick, a clear or an unused
//   action goes straight from idle to the response state. The next
//   transfer is taken once the result is loaded and the block is idle.
// Reset:
//   All entries invalid, time and last sweep time zero, registers at their
//   defaults. Memory contents are left as they are; no clearing pass.
// Stall:
//   The result sits in an output register; a stalled receiver holds it. The
//   next item is still taken and processed, and its result waits until the
//   register frees up; tready stays low meanwhile.
// ----------------------------------------------------------------------------
module tracked_emitter_table_core
  import tet_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: id_word0[63:0], id_word1[127:64], id_word2[159:128],
  //   station_address[207:160], is_ble[208], radio_channel[212:209],
  //   signal_dbm[220:213], has_drone_position[221], drone_position[285:222],
  //   has_pilot_position[286], pilot_position[350:287], zero fill[351]
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,   // action[1:0]
  // tdata: slot[4:0], evicted_address[52:5], expired_count[58:53],
  //   used_count[64:59], zero fill[71:65]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [2:0]          m_axis_tuser,   // outcome[2:0]
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned WA = IdW + AddrW + TimeW;   // match memory word
  localparam int unsigned WB = LinkW + 2 * PosW;      // payload memory word
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_WRITE, S_SWEEP, S_RESP
  } state_e;

  // ---------------- configuration ----------------
  logic [31:0] expire_limit_q;
  logic [15:0] sweep_period_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expire_limit_q <= ExpireLimitReset;
      sweep_period_q <= SweepPeriodReset;
    end else if (cfg_wr) begin
      if (paddr == RegExpireLimit) expire_limit_q <= pwdata;
      if (paddr == RegSweepPeriod) sweep_period_q <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (paddr)
      RegExpireLimit: prdata = expire_limit_q;
      RegSweepPeriod: prdata = {16'd0, sweep_period_q};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------- input unpacking and ID trim ----------------
  logic [IdW-1:0] id_raw, id_trim;
  logic [20:0]    id_keep;

  assign id_raw = {s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[159:128]};

  // bytes after the first zero byte are forced to zero
  always_comb begin
    id_keep[0] = 1'b1;
    id_trim    = id_raw;
    for (int b = 0; b < 20; b++) begin
      if (!id_keep[b]) id_trim[IdW-1-8*b -: 8] = 8'd0;
      id_keep[b+1] = id_keep[b] & (id_raw[IdW-1-8*b -: 8] != 8'd0);
    end
  end

  // ---------------- state ----------------
  state_e              state_q;
  logic                has_id_q;
  logic [IdW-1:0]      id_q;
  logic [AddrW-1:0]    addr_q;
  logic [12:0]         link_new_q;
  logic                has_drone_q, has_pilot_q;
  logic [PosW-1:0]     drone_q, pilot_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [CW-1:0]       used_q;
  logic [TimeW-1:0]    time_now_q, last_sweep_q;

  // scan control
  logic [IW-1:0]       idx_q, pidx_q;
  logic                issue_done_q, pend_q;
  logic                id_hit_q, addr_hit_q, free_hit_q;
  logic [IW-1:0]       id_slot_q, addr_slot_q, free_slot_q, old_slot_q;
  logic [TimeW-1:0]    oldest_q;
  logic [IW-1:0]       slot_q;

  // result
  logic [IW-1:0]       res_slot_q;
  logic [2:0]          res_outcome_q;
  logic [AddrW-1:0]    res_evict_q;
  logic [CW-1:0]       res_expired_q;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic [2:0]          m_user_q;

  // ---------------- memories ----------------
  logic [WA-1:0]  mem_a_q [TABLE_ENTRIES];
  logic [WB-1:0]  mem_b_q [TABLE_ENTRIES];
  logic [WA-1:0]  rd_a_q, wr_a;
  logic [WB-1:0]  rd_b_q, wr_b;
  logic [IW-1:0]  rd_idx;
  logic           mem_we;

  assign rd_idx = (state_q == S_READ) ? slot_q : idx_q;
  assign mem_we = (state_q == S_WRITE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_a_q[slot_q] <= wr_a;
      mem_b_q[slot_q] <= wr_b;
    end
    rd_a_q <= mem_a_q[rd_idx];
    rd_b_q <= mem_b_q[rd_idx];
  end

  logic [IdW-1:0]   rd_id;
  logic [AddrW-1:0] rd_addr;
  logic [TimeW-1:0] rd_seen, rd_age, tick_time, sweep_gap;
  logic [LinkW-1:0] rd_link, link_wr;
  logic [PosW-1:0]  rd_drone, rd_pilot;
  logic             fresh;   // slot is new or reused: start from cleared entry

  assign rd_id     = rd_a_q[WA-1 -: IdW];
  assign rd_addr   = rd_a_q[TimeW +: AddrW];
  assign rd_seen   = rd_a_q[TimeW-1:0];
  assign rd_age    = time_now_q - rd_seen;
  assign rd_link   = rd_b_q[WB-1 -: LinkW];
  assign rd_drone  = rd_b_q[PosW +: PosW];
  assign rd_pilot  = rd_b_q[PosW-1:0];
  assign tick_time = time_now_q + 32'd1;
  assign sweep_gap = tick_time - last_sweep_q;

  assign fresh = (res_outcome_q == OutFree) || (res_outcome_q == OutEvict);

  always_comb begin
    link_wr = {fresh ? 2'b00 : rd_link[14:13], link_new_q};
    if (has_drone_q) link_wr[13] = 1'b1;
    if (has_pilot_q) link_wr[14] = 1'b1;
    wr_a = {has_id_q ? id_q : (fresh ? {IdW{1'b0}} : rd_id), addr_q, time_now_q};
    wr_b = {link_wr,
            has_drone_q ? drone_q : (fresh ? {PosW{1'b0}} : rd_drone),
            has_pilot_q ? pilot_q : (fresh ? {PosW{1'b0}} : rd_pilot)};
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  logic [31:0] slot_ext, exp_ext, used_ext;
  assign slot_ext = 32'(res_slot_q);
  assign exp_ext  = 32'(res_expired_q);
  assign used_ext = 32'(used_q);

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      valid_q       <= '0;
      used_q        <= '0;
      time_now_q    <= '0;
      last_sweep_q  <= '0;
      m_valid_q     <= 1'b0;
      pend_q        <= 1'b0;
      issue_done_q  <= 1'b0;
      idx_q         <= '0;
    end else begin
      // output register: load a new result or drop the one taken
      if (state_q == S_RESP && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready)            m_valid_q <= 1'b0;

      // scan issue and pipeline tag, shared by detect and sweep scans
      if (state_q == S_SCAN || state_q == S_SWEEP) begin
        pend_q <= !issue_done_q;
        pidx_q <= idx_q;
        if (!issue_done_q) begin
          if (idx_q == LastIdx) issue_done_q <= 1'b1;
          else                  idx_q <= idx_q + 1'b1;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            has_id_q      <= id_raw[IdW-1 -: 8] != 8'd0;
            id_q          <= id_trim;
            addr_q        <= s_axis_tdata[207:160];
            link_new_q    <= s_axis_tdata[220:208];
            has_drone_q   <= s_axis_tdata[221];
            drone_q       <= s_axis_tdata[285:222];
            has_pilot_q   <= s_axis_tdata[286];
            pilot_q       <= s_axis_tdata[350:287];
            idx_q         <= '0;
            issue_done_q  <= 1'b0;
            pend_q        <= 1'b0;
            id_hit_q      <= 1'b0;
            addr_hit_q    <= 1'b0;
            free_hit_q    <= 1'b0;
            oldest_q      <= '0;
            old_slot_q    <= '0;
            res_slot_q    <= '0;
            res_outcome_q <= OutTick;
            res_evict_q   <= '0;
            res_expired_q <= '0;
            unique case (s_axis_tuser)
              ActDetect: state_q <= S_SCAN;
              ActTick: begin
                time_now_q <= tick_time;
                if (sweep_gap >= {16'd0, sweep_period_q}) begin
                  last_sweep_q  <= tick_time;
                  res_outcome_q <= OutSweep;
                  state_q       <= S_SWEEP;
                end else begin
                  state_q <= S_RESP;
                end
              end
              ActClear: begin
                valid_q <= '0;
                used_q  <= '0;
                state_q <= S_RESP;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end

        S_SCAN: begin
          if (pend_q) begin
            if (valid_q[pidx_q] && has_id_q && rd_id == id_q && !id_hit_q) begin
              id_hit_q  <= 1'b1;
              id_slot_q <= pidx_q;
            end
            if (valid_q[pidx_q] && rd_addr == addr_q && !addr_hit_q) begin
              addr_hit_q  <= 1'b1;
              addr_slot_q <= pidx_q;
            end
            if (!valid_q[pidx_q] && !free_hit_q) begin
              free_hit_q  <= 1'b1;
              free_slot_q <= pidx_q;
            end
            if (rd_age > oldest_q) begin
              oldest_q   <= rd_age;
              old_slot_q <= pidx_q;
            end
          end else if (issue_done_q) begin
            // all entries seen: pick the slot
            priority if (id_hit_q) begin
              slot_q <= id_slot_q;  res_outcome_q <= OutIdHit;
            end else if (addr_hit_q) begin
              slot_q <= addr_slot_q; res_outcome_q <= OutAddrHit;
            end else if (free_hit_q) begin
              slot_q <= free_slot_q; res_outcome_q <= OutFree;
              used_q <= used_q + 1'b1;
            end else begin
              slot_q <= old_slot_q;  res_outcome_q <= OutEvict;
            end
            state_q <= S_READ;
          end
        end

        S_READ: state_q <= S_WRITE;

        S_WRITE: begin
          // read data of the slot is in rd_*; write back merged entry
          valid_q[slot_q] <= 1'b1;
          res_slot_q      <= slot_q;
          if (res_outcome_q == OutEvict) res_evict_q <= rd_addr;
          state_q         <= S_RESP;
        end

        S_SWEEP: begin
          if (pend_q) begin
            if (valid_q[pidx_q] && rd_age > expire_limit_q) begin
              valid_q[pidx_q] <= 1'b0;
              res_expired_q   <= res_expired_q + 1'b1;
              used_q          <= used_q - 1'b1;
            end
          end else if (issue_done_q) begin
            state_q <= S_RESP;
          end
        end

        S_RESP: begin
          if (out_free) begin
            m_user_q  <= res_outcome_q;
            m_data_q  <= {7'd0, used_ext[5:0], exp_ext[5:0], res_evict_q, slot_ext[4:0]};
            state_q   <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
